/* rtl/omta_pkg.sv */
// ----------------------------------------------------------------------------
// omta_pkg
// Shared types, widths and tree shape helpers for the 8-ary max/argmax tree.
// ----------------------------------------------------------------------------
package omta_pkg;

   localparam int LEAF_IDX_W = 12;
   localparam int VAL_W      = 31;
   localparam int LEAVES_DEF = 4096;
   localparam int FANOUT_DEF = 8;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_UP_RD,
      ST_UP_WR,
      ST_TOP_RD,
      ST_TOP,
      ST_DN_RD,
      ST_DN_CMP
   } omta_state_type;

   // number of groups of f in n nodes (ceil), elaboration only
   function automatic int groups_of(input int n, input int f);
      int g;
      int s;
      g = 0;
      s = 0;
      while (s < n) begin
         s = s + f;
         g = g + 1;
      end
      return g;
   endfunction

   function automatic int level_count(input int leaves, input int f);
      int n;
      int c;
      n = leaves;
      c = 1;
      while (n > 1) begin
         n = groups_of(n, f);
         c = c + 1;
      end
      return c;
   endfunction

   // first row of level k; with k = level count it is the total row count
   function automatic int row_offset(input int leaves, input int f, input int k);
      int n;
      int off;
      int g;
      n   = leaves;
      off = 0;
      for (int j = 0; j < k; j++) begin
         g   = groups_of(n, f);
         off = off + g;
         n   = g;
      end
      return off;
   endfunction

endpackage

/* rtl/omta_row_alu.sv */
// ----------------------------------------------------------------------------
// omta_row_alu
// Shared row unit: merges one child into a row, reduces the row to its
// maximum, and finds the first child equal to a key.
// ----------------------------------------------------------------------------
module omta_row_alu #(
   parameter int FANOUT = omta_pkg::FANOUT_DEF
) (
   input  logic [FANOUT*omta_pkg::VAL_W-1:0]   row_i,
   input  logic [$clog2(FANOUT)-1:0]           slot_i,
   input  logic [omta_pkg::VAL_W-1:0]          value_i,
   input  logic                                merge_i,
   input  logic [omta_pkg::VAL_W-1:0]          key_i,
   output logic [FANOUT*omta_pkg::VAL_W-1:0]   row_o,
   output logic [omta_pkg::VAL_W-1:0]          max_o,
   output logic [$clog2(FANOUT)-1:0]           match_slot_o,
   output logic                                match_o
);
   import omta_pkg::*;

   localparam int SLOT_W = $clog2(FANOUT);
   localparam int PAD    = 2 ** SLOT_W;

   logic [VAL_W-1:0] child [FANOUT];
   logic [VAL_W-1:0] node  [2*PAD-1];

   for (genvar i = 0; i < FANOUT; i++) begin : g_child
      assign child[i] = (merge_i && (slot_i == SLOT_W'(i))) ? value_i
                                                           : row_i[i*VAL_W +: VAL_W];
      assign row_o[i*VAL_W +: VAL_W] = child[i];
   end

   for (genvar i = 0; i < PAD; i++) begin : g_leaf
      if (i < FANOUT) begin : g_real
         assign node[PAD-1+i] = child[i];
      end else begin : g_pad
         assign node[PAD-1+i] = '0;
      end
   end

   for (genvar n = 0; n < PAD-1; n++) begin : g_tree
      assign node[n] = (node[2*n+1] >= node[2*n+2]) ? node[2*n+1] : node[2*n+2];
   end

   assign max_o = node[0];

   always_comb begin
      match_o      = 1'b0;
      match_slot_o = '0;
      for (int i = FANOUT-1; i >= 0; i--) begin
         if (child[i] == key_i) begin
            match_o      = 1'b1;
            match_slot_o = SLOT_W'(i);
         end
      end
   end

endmodule

/* rtl/octal_max_tree_argmax.sv */
// ----------------------------------------------------------------------------
// octal_max_tree_argmax
// FANOUT-ary max tournament tree over LEAVES leaves with argmax on descent.
// ----------------------------------------------------------------------------
// Each transfer overwrites one leaf, updates the group maxima up to the root
// and returns the root maximum and the first leaf holding it. All levels live
// as rows of FANOUT entries in one single-port-write RAM with registered read;
// one row unit does every merge, max and match. The tree has L levels (5 at the
// defaults). An in-range item goes through one divide state, a read and a
// write state per level on the way up, the root read states, then read and
// compare states on the way down; the last compare waits until the output
// register is free. An out-of-range index skips the update. req_ready is high
// only while idle, so a new item is taken only after the previous result has
// been loaded. After reset a clearing pass writes zero to every row, one row
// per cycle, before the first transfer is taken.
// ----------------------------------------------------------------------------
module octal_max_tree_argmax #(
   parameter int LEAVES = omta_pkg::LEAVES_DEF,
   parameter int FANOUT = omta_pkg::FANOUT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [omta_pkg::LEAF_IDX_W-1:0]   req_leaf_index,
   input  logic [omta_pkg::VAL_W-1:0]        req_leaf_value,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [omta_pkg::LEAF_IDX_W-1:0]   rsp_top_index,
   output logic [omta_pkg::VAL_W-1:0]        rsp_top_value
);
   import omta_pkg::*;

   localparam int LEVELS  = level_count(LEAVES, FANOUT);
   localparam int ROWS    = row_offset(LEAVES, FANOUT, LEVELS);
   localparam int ROW_AW  = $clog2(ROWS);
   localparam int LVL_W   = $clog2(LEVELS);
   localparam int NODE_W  = $clog2(LEAVES);
   localparam int SLOT_W  = $clog2(FANOUT);
   localparam int ROW_W   = FANOUT * VAL_W;
   localparam int MUL_W   = NODE_W + SLOT_W + 1;
   localparam int DIV_SH  = NODE_W + 5;
   localparam int RECIP   = (2 ** DIV_SH + FANOUT - 1) / FANOUT;
   localparam int PROD_W  = NODE_W + DIV_SH + 1;
   localparam bit ALL_IN  = (LEAVES >= 2 ** LEAF_IDX_W);

   // row offset of each level
   logic [ROW_AW-1:0] row_off [LEVELS];
   for (genvar k = 0; k < LEVELS; k++) begin : g_off
      assign row_off[k] = ROW_AW'(row_offset(LEAVES, FANOUT, k));
   end

   omta_state_type     state_ff, state_in;
   logic [ROW_AW-1:0]  clr_ff, clr_in;
   logic [NODE_W-1:0]  idx_ff, idx_in;
   logic [NODE_W-1:0]  q_ff, q_in;
   logic [NODE_W-1:0]  pos_ff, pos_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [VAL_W-1:0]   val_ff, val_in;
   logic [VAL_W-1:0]   top_ff, top_in;
   logic [LVL_W-1:0]   lvl_ff, lvl_in;
   logic [ROW_AW-1:0]  wr_addr_ff, wr_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEAF_IDX_W-1:0] rsp_top_index_ff, rsp_top_index_in;
   logic [VAL_W-1:0]   rsp_top_value_ff, rsp_top_value_in;

   logic [ROW_W-1:0]   mem [ROWS];
   logic [ROW_W-1:0]   rd_data_ff;
   logic               mem_we;
   logic [ROW_AW-1:0]  mem_wr_addr;
   logic [ROW_W-1:0]   mem_wr_data;
   logic               mem_re;
   logic [ROW_AW-1:0]  mem_rd_addr;

   logic               in_range;
   logic               out_free;
   logic               last_dn;
   logic               rsp_load;
   logic [LVL_W-1:0]   lvl_dn;
   logic [NODE_W-1:0]  div_arg;
   logic [PROD_W-1:0]  div_prod;
   logic [NODE_W-1:0]  div_quot;
   logic [NODE_W-1:0]  rem_full;
   logic [NODE_W-1:0]  next_pos;

   logic [ROW_W-1:0]   alu_row;
   logic [VAL_W-1:0]   alu_max;
   logic [SLOT_W-1:0]  alu_slot;
   logic               alu_match;
   logic               alu_merge;

   assign in_range = ALL_IN || (req_leaf_index < LEAF_IDX_W'(LEAVES));
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign last_dn  = (lvl_ff == LVL_W'(1));
   assign rsp_load = (state_ff == ST_DN_CMP) && last_dn && out_free;
   assign lvl_dn   = lvl_ff - LVL_W'(1);

   // constant divide by FANOUT: reciprocal multiply, exact for NODE_W-bit args
   assign div_arg  = (state_ff == ST_DIV) ? idx_ff : q_ff;
   assign div_prod = PROD_W'(div_arg) * PROD_W'(RECIP);
   assign div_quot = NODE_W'(div_prod >> DIV_SH);
   assign rem_full = NODE_W'(MUL_W'(idx_ff) - MUL_W'(q_ff) * MUL_W'(FANOUT));
   assign next_pos = NODE_W'(MUL_W'(pos_ff) * MUL_W'(FANOUT) + MUL_W'(alu_slot));

   assign alu_merge = (state_ff == ST_UP_WR);

   omta_row_alu #(
      .FANOUT (FANOUT)
   ) u_row_alu (
      .row_i        (rd_data_ff),
      .slot_i       (slot_ff),
      .value_i      (val_ff),
      .merge_i      (alu_merge),
      .key_i        (top_ff),
      .row_o        (alu_row),
      .max_o        (alu_max),
      .match_slot_o (alu_slot),
      .match_o      (alu_match)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == ROW_AW'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               state_in = in_range ? ST_DIV : ST_TOP_RD;
            end
         end
         ST_DIV:    state_in = ST_UP_RD;
         ST_UP_RD:  state_in = ST_UP_WR;
         ST_UP_WR: begin
            state_in = (lvl_ff == LVL_W'(LEVELS - 1)) ? ST_TOP_RD : ST_UP_RD;
         end
         ST_TOP_RD: state_in = ST_TOP;
         ST_TOP:    state_in = ST_DN_CMP;
         ST_DN_RD:  state_in = ST_DN_CMP;
         ST_DN_CMP: begin
            if (!last_dn) begin
               state_in = ST_DN_RD;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_CLEAR;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready   = 1'b0;
      mem_we      = 1'b0;
      mem_wr_addr = wr_addr_ff;
      mem_wr_data = alu_row;
      mem_re      = 1'b0;
      mem_rd_addr = row_off[lvl_dn] + ROW_AW'(pos_ff);
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we      = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
         end
         ST_IDLE:  req_ready = 1'b1;
         ST_UP_RD: begin
            mem_re      = 1'b1;
            mem_rd_addr = row_off[lvl_ff] + ROW_AW'(q_ff);
         end
         ST_UP_WR: mem_we = 1'b1;
         ST_TOP_RD: begin
            mem_re      = 1'b1;
            mem_rd_addr = row_off[LEVELS-1];
         end
         ST_TOP, ST_DN_RD: mem_re = 1'b1;
         ST_DIV, ST_DN_CMP: begin
         end
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      clr_in     = clr_ff;
      idx_in     = idx_ff;
      q_in       = q_ff;
      pos_in     = pos_ff;
      slot_in    = slot_ff;
      val_in     = val_ff;
      top_in     = top_ff;
      lvl_in     = lvl_ff;
      wr_addr_in = wr_addr_ff;
      case (state_ff)
         ST_CLEAR: clr_in = clr_ff + ROW_AW'(1);
         ST_IDLE: begin
            idx_in = NODE_W'(req_leaf_index);
            val_in = req_leaf_value;
            lvl_in = '0;
         end
         ST_DIV: q_in = div_quot;
         ST_UP_RD: begin
            slot_in    = SLOT_W'(rem_full);
            wr_addr_in = mem_rd_addr;
         end
         ST_UP_WR: begin
            val_in = alu_max;
            idx_in = q_ff;
            q_in   = div_quot;
            if (lvl_ff != LVL_W'(LEVELS - 1)) begin
               lvl_in = lvl_ff + LVL_W'(1);
            end
         end
         ST_TOP_RD: begin
            lvl_in = LVL_W'(LEVELS - 1);
            pos_in = '0;
         end
         ST_TOP: top_in = rd_data_ff[VAL_W-1:0];
         ST_DN_CMP: begin
            if (!last_dn) begin
               pos_in = next_pos;
               lvl_in = lvl_dn;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_top_index_in = rsp_top_index_ff;
      rsp_top_value_in = rsp_top_value_ff;
      if (rsp_load) begin
         rsp_valid_in     = 1'b1;
         rsp_top_index_in = LEAF_IDX_W'(next_pos);
         rsp_top_value_in = top_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff           <= idx_in;
      q_ff             <= q_in;
      pos_ff           <= pos_in;
      slot_ff          <= slot_in;
      val_ff           <= val_in;
      top_ff           <= top_in;
      lvl_ff           <= lvl_in;
      wr_addr_ff       <= wr_addr_in;
      rsp_top_index_ff <= rsp_top_index_in;
      rsp_top_value_ff <= rsp_top_value_in;
   end

   // row RAM
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_rd_addr];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_top_index = rsp_top_index_ff;
   assign rsp_top_value = rsp_top_value_ff;

   a_rsp_from_descent: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DN_CMP))
      else $error("result raised outside descent");

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !mem_we)
      else $error("RAM write while idle");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UP_WR) |-> ({1'b0, slot_ff} < (SLOT_W+1)'(FANOUT)))
      else $error("child slot out of range");

   a_desc_match: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DN_CMP) |-> alu_match)
      else $error("no child equals parent on descent");

endmodule
